FILE: rtl/penum_pkg.sv
// ----------------------------------------------------------------------------
// penum_pkg: shared types for the permutation enumerator
// Request codes, micro-op and jump-condition codes, the control word and its
// read-only microcode table, and the structs passed between the sequencer
// and the datapath.
// ----------------------------------------------------------------------------
package penum_pkg;

  localparam int VALUE_W    = 32;
  localparam int POS_W      = 4;
  localparam int IN_TDATA_W = 32;
  localparam int OUT_TDATA_W = 40;  // value, position, zero fill to 5 bytes
  localparam int UPC_W      = 5;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_NEXT  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    U_NOP,
    U_CLEAR,
    U_LOAD,
    U_PIV_INIT,
    U_PIV_STEP,
    U_SUCC_INIT,
    U_SUCC_SCAN,
    U_REV_INIT,
    U_REV_READ,
    U_REV_SWAP,
    U_EMIT_INIT,
    U_EMIT_READ,
    U_EMIT_OUT,
    U_EXH_OUT
  } uop_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_DISPATCH,
    C_EXH,
    C_NOT_STARTED,
    C_SHORT,
    C_A_ZERO,
    C_GE,
    C_LE,
    C_A_GE_B,
    C_K_LAST
  } cond_t;

  typedef struct packed {
    uop_t             uop;
    cond_t            cond;
    logic             wait_out;  // step holds while the output register is full and not draining
    logic [UPC_W-1:0] target;
  } ucw_t;

  typedef struct packed {
    uop_t uop;
    logic fire;
  } dp_ctrl_t;

  typedef struct packed {
    logic exh;
    logic not_started;
    logic short_set;
    logic a_zero;
    logic rd_ge;
    logic rd_le;
    logic a_ge_b;
    logic k_last;
    logic out_busy;
  } dp_stat_t;

  // microcode step addresses
  localparam logic [UPC_W-1:0] STEP_IDLE      = 5'd0;
  localparam logic [UPC_W-1:0] STEP_CLEAR     = 5'd1;
  localparam logic [UPC_W-1:0] STEP_LOAD      = 5'd2;
  localparam logic [UPC_W-1:0] STEP_NEXT      = 5'd3;
  localparam logic [UPC_W-1:0] STEP_CHK_START = 5'd4;
  localparam logic [UPC_W-1:0] STEP_PIV_INIT  = 5'd5;
  localparam logic [UPC_W-1:0] STEP_PIV_CHK   = 5'd6;
  localparam logic [UPC_W-1:0] STEP_PIV_STEP  = 5'd7;
  localparam logic [UPC_W-1:0] STEP_SUCC_INIT = 5'd8;
  localparam logic [UPC_W-1:0] STEP_SUCC_SCAN = 5'd9;
  localparam logic [UPC_W-1:0] STEP_REV_INIT  = 5'd10;
  localparam logic [UPC_W-1:0] STEP_REV_READ  = 5'd11;
  localparam logic [UPC_W-1:0] STEP_REV_SWAP  = 5'd12;
  localparam logic [UPC_W-1:0] STEP_EMIT_INIT = 5'd13;
  localparam logic [UPC_W-1:0] STEP_EMIT_OUT  = 5'd14;
  localparam logic [UPC_W-1:0] STEP_EMIT_READ = 5'd15;
  localparam logic [UPC_W-1:0] STEP_EXH       = 5'd16;

  function automatic ucw_t mk(uop_t u, cond_t c, logic w, logic [UPC_W-1:0] t);
    ucw_t r;
    r.uop      = u;
    r.cond     = c;
    r.wait_out = w;
    r.target   = t;
    return r;
  endfunction

  // microcode ROM: condition true jumps to target, else falls to the next step
  function automatic ucw_t ucode_rom(logic [UPC_W-1:0] upc);
    ucw_t r;
    case (upc)
      STEP_IDLE:      r = mk(U_NOP,       C_DISPATCH,    1'b0, STEP_IDLE);
      STEP_CLEAR:     r = mk(U_CLEAR,     C_ALWAYS,      1'b0, STEP_IDLE);
      STEP_LOAD:      r = mk(U_LOAD,      C_ALWAYS,      1'b0, STEP_IDLE);
      STEP_NEXT:      r = mk(U_NOP,       C_EXH,         1'b0, STEP_EXH);
      STEP_CHK_START: r = mk(U_NOP,       C_NOT_STARTED, 1'b0, STEP_EMIT_INIT);
      STEP_PIV_INIT:  r = mk(U_PIV_INIT,  C_SHORT,       1'b0, STEP_EXH);
      STEP_PIV_CHK:   r = mk(U_NOP,       C_A_ZERO,      1'b0, STEP_EXH);
      STEP_PIV_STEP:  r = mk(U_PIV_STEP,  C_GE,          1'b0, STEP_PIV_CHK);
      STEP_SUCC_INIT: r = mk(U_SUCC_INIT, C_NEVER,       1'b0, STEP_IDLE);
      STEP_SUCC_SCAN: r = mk(U_SUCC_SCAN, C_LE,          1'b0, STEP_SUCC_SCAN);
      STEP_REV_INIT:  r = mk(U_REV_INIT,  C_NEVER,       1'b0, STEP_IDLE);
      STEP_REV_READ:  r = mk(U_REV_READ,  C_A_GE_B,      1'b0, STEP_EMIT_INIT);
      STEP_REV_SWAP:  r = mk(U_REV_SWAP,  C_ALWAYS,      1'b0, STEP_REV_READ);
      STEP_EMIT_INIT: r = mk(U_EMIT_INIT, C_ALWAYS,      1'b0, STEP_EMIT_READ);
      STEP_EMIT_OUT:  r = mk(U_EMIT_OUT,  C_K_LAST,      1'b1, STEP_IDLE);
      STEP_EMIT_READ: r = mk(U_EMIT_READ, C_ALWAYS,      1'b0, STEP_EMIT_OUT);
      STEP_EXH:       r = mk(U_EXH_OUT,   C_ALWAYS,      1'b1, STEP_IDLE);
      default:        r = mk(U_NOP,       C_ALWAYS,      1'b0, STEP_IDLE);
    endcase
    return r;
  endfunction

  function automatic logic [UPC_W-1:0] step_dispatch(func_t f);
    logic [UPC_W-1:0] s;
    case (f)
      FUNC_CLEAR: s = STEP_CLEAR;
      FUNC_LOAD:  s = STEP_LOAD;
      FUNC_NEXT:  s = STEP_NEXT;
      default:    s = STEP_IDLE;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/permutation_enumerator.sv
// ----------------------------------------------------------------------------
// permutation_enumerator: stepwise permutation generator
// Loads up to MAX_ITEMS signed values and streams their permutations in
// lexicographic order of the stored index sequence, one value per result.
// ----------------------------------------------------------------------------
// Each request carries a code in s_tuser: clear (0) empties the set and
// restarts, load (1) appends s_tdata to the set and restarts from the identity
// order (ignored once MAX_ITEMS values are held), next (2) streams the
// following permutation, and code 3 does nothing. A permutation of n values
// comes out as n results with m_tlast on the final one; position counts from
// 0. When no permutation remains, or the set is empty, a next request gives a
// single result with m_tuser (exhausted) and m_tlast set and zero data.
// Operation: the block is run by a microcode sequencer over a single-read-port
// index array, so one request is handled at a time. The first permutation
// after a clear or load is a setup step, then each element is emitted through
// the value RAM's registered read. Later permutations first run a pivot scan,
// a successor scan and a suffix reversal; a pivot scan that finds no successor
// ends in the exhausted report. A full output register that waits on m_tready
// holds the sequencer at its output steps. Results sit in an output register,
// so the block returns to accept the next request while the last result still
// waits on m_tready.
// ----------------------------------------------------------------------------
module permutation_enumerator #(
  parameter int MAX_ITEMS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] item_value
  input  logic [1:0]  s_tuser,   // [1:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] out_value, [35:32] position, [39:36] zero
  output logic        m_tlast,   // last
  output logic        m_tuser    // exhausted
);
  import penum_pkg::*;

  localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  dp_ctrl_t dc;
  dp_stat_t st;
  logic     accept;

  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic               ram_re;
  logic [IW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  // a request is taken only while the sequencer sits in its idle step
  assign accept = s_tvalid && s_tready;

  penum_useq u_seq (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .func     (func_t'(s_tuser)),
    .st       (st),
    .dc       (dc),
    .ready    (s_tready)
  );

  penum_dpath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_value  (s_tdata),
    .dc        (dc),
    .st        (st),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  // loaded values; only entries below the element count are ever read
  penum_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_ITEMS)
  ) u_values (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

FILE: rtl/penum_ram.sv
// ----------------------------------------------------------------------------
// penum_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds while re is low.
// ----------------------------------------------------------------------------
module penum_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/penum_useq.sv
// ----------------------------------------------------------------------------
// penum_useq: microcode sequencer
// Step counter over the control ROM, request dispatch and conditional jumps.
// ----------------------------------------------------------------------------
module penum_useq (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  penum_pkg::func_t    func,
  input  penum_pkg::dp_stat_t st,
  output penum_pkg::dp_ctrl_t dc,
  output logic                ready
);
  import penum_pkg::*;

  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  ucw_t             cw;
  logic             stall;
  logic             take;

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= STEP_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  always_comb begin
    cw    = ucode_rom(upc);
    stall = cw.wait_out && st.out_busy;
    case (cw.cond)
      C_ALWAYS:      take = 1'b1;
      C_EXH:         take = st.exh;
      C_NOT_STARTED: take = st.not_started;
      C_SHORT:       take = st.short_set;
      C_A_ZERO:      take = st.a_zero;
      C_GE:          take = st.rd_ge;
      C_LE:          take = st.rd_le;
      C_A_GE_B:      take = st.a_ge_b;
      C_K_LAST:      take = st.k_last;
      default:       take = 1'b0;
    endcase
    if (stall) begin
      upc_next = upc;
    end else if (cw.cond == C_DISPATCH) begin
      upc_next = s_tvalid ? step_dispatch(func) : cw.target;
    end else if (take) begin
      upc_next = cw.target;
    end else begin
      upc_next = upc + UPC_W'(1);
    end
    dc.uop  = cw.uop;
    dc.fire = !stall;
    ready   = (upc == STEP_IDLE);
  end

endmodule

FILE: rtl/penum_dpath.sv
// ----------------------------------------------------------------------------
// penum_dpath: enumerator datapath
// Index order array with one read port, cursors, flags and output register.
// ----------------------------------------------------------------------------
module penum_dpath #(
  parameter int MAX_ITEMS = 8,
  localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
  localparam int CW = $clog2(MAX_ITEMS + 1)
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     accept,
  input  logic signed [penum_pkg::VALUE_W-1:0]     in_value,
  input  penum_pkg::dp_ctrl_t                      dc,
  output penum_pkg::dp_stat_t                      st,
  output logic                                     ram_we,
  output logic [IW-1:0]                            ram_waddr,
  output logic [penum_pkg::VALUE_W-1:0]            ram_wdata,
  output logic                                     ram_re,
  output logic [IW-1:0]                            ram_raddr,
  input  logic [penum_pkg::VALUE_W-1:0]            ram_rdata,
  input  logic                                     m_tready,
  output logic                                     m_tvalid,
  output logic [penum_pkg::OUT_TDATA_W-1:0]        m_tdata,
  output logic                                     m_tlast,
  output logic                                     m_tuser
);
  import penum_pkg::*;

  logic [IW-1:0] idx [MAX_ITEMS];
  logic [CW-1:0] count;
  logic          started;
  logic          done;

  logic [IW-1:0] a, b, p, t, k;
  logic signed [VALUE_W-1:0] value_l;

  logic signed [VALUE_W-1:0] out_value;
  logic [POS_W-1:0]          out_pos;
  logic                      out_last;
  logic                      out_exh;
  logic                      out_valid;

  logic [IW-1:0] n_m1;
  logic [IW-1:0] a_m1;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] idx_rd;
  logic          full;
  logic          go;

  always_comb begin
    n_m1 = IW'(count - CW'(1));
    a_m1 = a - IW'(1);
    full = (count == CW'(MAX_ITEMS));
    go   = dc.fire;
    case (dc.uop)
      U_PIV_INIT:               rd_addr = n_m1;
      U_PIV_STEP:               rd_addr = a_m1;
      U_SUCC_SCAN, U_REV_SWAP:  rd_addr = b;
      U_REV_READ:               rd_addr = a;
      default:                  rd_addr = k;
    endcase
    idx_rd = idx[rd_addr];

    st.exh         = done || (count == '0);
    st.not_started = !started;
    st.short_set   = (count <= CW'(1));
    st.a_zero      = (a == '0);
    st.rd_ge       = (idx_rd >= t);
    st.rd_le       = (idx_rd <= t);
    st.a_ge_b      = (a >= b);
    st.k_last      = (k == n_m1);
    st.out_busy    = out_valid && !m_tready;

    ram_we    = go && (dc.uop == U_LOAD) && !full;
    ram_waddr = count[IW-1:0];
    ram_wdata = value_l;
    ram_re    = go && (dc.uop == U_EMIT_READ);
    ram_raddr = idx_rd;

    m_tvalid = out_valid;
    m_tdata  = {{(OUT_TDATA_W - VALUE_W - POS_W){1'b0}}, out_pos, out_value};
    m_tlast  = out_last;
    m_tuser  = out_exh;
  end

  // control state: index order, count, flags, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      started   <= 1'b0;
      done      <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_ITEMS; i++) begin
        idx[i] <= IW'(i);
      end
    end else begin
      // a new result may replace one that drains in the same cycle
      if (go && (dc.uop == U_EMIT_OUT || dc.uop == U_EXH_OUT)) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (go) begin
        case (dc.uop)
          U_CLEAR: begin
            count   <= '0;
            started <= 1'b0;
            done    <= 1'b0;
            for (int i = 0; i < MAX_ITEMS; i++) begin
              idx[i] <= IW'(i);
            end
          end
          U_LOAD: begin
            if (!full) begin
              count   <= count + CW'(1);
              started <= 1'b0;
              done    <= 1'b0;
              for (int i = 0; i < MAX_ITEMS; i++) begin
                idx[i] <= IW'(i);
              end
            end
          end
          U_SUCC_SCAN: begin
            if (!(idx_rd <= t)) begin
              idx[p] <= idx_rd;
              idx[b] <= t;
            end
          end
          U_REV_SWAP: begin
            idx[a] <= idx_rd;
            idx[b] <= t;
          end
          U_EMIT_INIT: started <= 1'b1;
          U_EXH_OUT:   done    <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  // cursors and payload
  always_ff @(posedge clk) begin
    if (accept) begin
      value_l <= in_value;
    end
    if (go) begin
      case (dc.uop)
        U_PIV_INIT: begin
          a <= n_m1;
          t <= idx_rd;
        end
        U_PIV_STEP: begin
          t <= idx_rd;
          if (idx_rd >= t) begin
            a <= a_m1;
          end else begin
            p <= a_m1;
          end
        end
        U_SUCC_INIT: b <= n_m1;
        U_SUCC_SCAN: begin
          if (idx_rd <= t) begin
            b <= b - IW'(1);
          end
        end
        U_REV_INIT: begin
          a <= p + IW'(1);
          b <= n_m1;
        end
        U_REV_READ: t <= idx_rd;
        U_REV_SWAP: begin
          a <= a + IW'(1);
          b <= b - IW'(1);
        end
        U_EMIT_INIT: k <= '0;
        U_EMIT_OUT: begin
          out_value <= ram_rdata;
          out_pos   <= POS_W'(k);
          out_last  <= (k == n_m1);
          out_exh   <= 1'b0;
          k         <= k + IW'(1);
        end
        U_EXH_OUT: begin
          out_value <= '0;
          out_pos   <= '0;
          out_last  <= 1'b1;
          out_exh   <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // an exhausted report is always a single, final result
  a_exh_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_exh) |-> (out_last && out_pos == '0))
    else $error("exhausted report without last");

  // emission never runs past the last loaded element
  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    (go && dc.uop == U_EMIT_OUT) |-> (k <= n_m1))
    else $error("emit cursor beyond element count");

  // successor scan stops before reaching the pivot
  a_succ_pivot: assert property (@(posedge clk) disable iff (rst)
    (dc.uop == U_SUCC_SCAN) |-> (b > p))
    else $error("successor scan crossed pivot");

  // a new result is loaded only into a free or draining output register
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (go && (dc.uop == U_EMIT_OUT || dc.uop == U_EXH_OUT)) |-> (!out_valid || m_tready))
    else $error("output register overrun");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ITEMS))
    else $error("element count above capacity");

endmodule
